FILE: design/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset
`define BFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset
`define BFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Types and constants of the bitmap first-fit block allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int unsigned BlockBytesDef = 128;
  localparam int unsigned BlockCountDef = 2048;
  localparam logic [31:0] HeapBaseReset = 32'h0900_0000;

  localparam int unsigned WordBits = 32;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_ILLEGAL_SIZE  = 2'd1,
    ST_NO_MEMORY     = 2'd2,
    ST_NOT_ALLOCATED = 2'd3
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_FREE_RD,
    S_FREE_CHK,
    S_MARK_RD,
    S_MARK_WR,
    S_DONE
  } state_e;

endpackage

FILE: design/bfa_ram.sv
// ----------------------------------------------------------------------------
// bfa_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Read one entry per cycle, and write it too when we_i is high; the read gives the old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

FILE: design/bitmap_first_fit_block_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_first_fit_block_allocator_core
// First-fit block allocator; bitmap and run-length table held in RAMs.
// ----------------------------------------------------------------------------
// channel | direction | handshake
// req     | in        | req_valid_i / req_ready_o
// rsp     | out       | rsp_valid_o / rsp_ready_i
// cfg     | in        | cfg_we_i, write only
//
// After reset a clearing pass writes every map word and every run-length
// entry, while no request is taken. Allocate: each map word up to the first
// fit (64 words for the default map) is read, then checked; each word marked
// is read, then written. Free: the run-length entry is read, then checked;
// each word cleared is read, then written; single-port RAMs set these steps.
// One request is worked at a time; a waiting response blocks the next one.
module bitmap_first_fit_block_allocator_core #(
  parameter int unsigned BlockBytes = bfa_pkg::BlockBytesDef,
  parameter int unsigned BlockCount = bfa_pkg::BlockCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic        operation_i,
  input  logic [19:0] size_bytes_i,
  input  logic [31:0] address_i,
  output logic        rsp_valid_o,
  input  logic        rsp_ready_i,
  output logic [31:0] block_address_o,
  output logic [1:0]  status_o
);

  import bfa_pkg::*;

  localparam int unsigned Words = (BlockCount + WordBits - 1) / WordBits;
  localparam int unsigned WaW = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned IdxW = $clog2(BlockCount);
  localparam int unsigned CntW = $clog2(BlockCount + 1);
  localparam int unsigned ShW = $clog2(BlockBytes);
  localparam int unsigned LastBits = BlockCount - (Words - 1) * WordBits;

  state_e state_q, state_d;
  logic [31:0] heap_base_q;
  logic [WaW-1:0] wa_q, wa_d;
  logic [IdxW-1:0] clr_q, clr_d;
  logic [CntW-1:0] need_q, need_d, run_q, run_d, left_q, left_d;
  logic [IdxW:0] start_q, start_d;
  logic [IdxW:0] pos_q, pos_d;
  logic [31:0] rsp_addr_q, rsp_addr_d;
  logic [1:0] rsp_st_q, rsp_st_d;
  logic op_q, op_d;

  logic map_we, len_we;
  logic [WaW-1:0] map_addr;
  logic [WordBits-1:0] map_wdata, map_rdata, word_eff;
  logic [IdxW-1:0] len_addr;
  logic [CntW-1:0] len_wdata, len_rdata;

  bfa_ram #(.Width(WordBits), .Depth(Words)) u_map (
    .clk_i(clk_i), .we_i(map_we), .addr_i(map_addr),
    .wdata_i(map_wdata), .rdata_o(map_rdata)
  );

  bfa_ram #(.Width(CntW), .Depth(BlockCount)) u_len (
    .clk_i(clk_i), .we_i(len_we), .addr_i(len_addr),
    .wdata_i(len_wdata), .rdata_o(len_rdata)
  );

  // Treat blocks past the end of the map as used
  always_comb begin
    word_eff = map_rdata;
    if (wa_q == WaW'(Words - 1)) begin
      for (int b = 0; b < WordBits; b++) begin
        if (b >= LastBits) word_eff[b] = 1'b1;
      end
    end
  end

  // Scan of one word, all bit positions in parallel: a position fits when the
  // free run ending there (carried run plus free prefix, or the free bits
  // since the last used one) reaches the request length
  logic [WordBits-1:0] pre_free, fit_at;
  logic [WordBits:1]   need_ge;
  logic                fit_found;
  logic [4:0]          fit_bit;
  logic [4:0]          top_used;
  logic [CntW-1:0]     run_end;
  always_comb begin
    logic blocked;
    for (int d = 1; d <= WordBits; d++) begin
      need_ge[d] = (need_q >= CntW'(d));
    end
    pre_free[0] = !word_eff[0];
    for (int b = 1; b < WordBits; b++) begin
      pre_free[b] = pre_free[b-1] & !word_eff[b];
    end
    for (int b = 0; b < WordBits; b++) begin
      blocked = 1'b0;
      for (int k = 0; k <= b; k++) begin
        blocked = blocked | (word_eff[k] & need_ge[b - k + 1]);
      end
      fit_at[b] = pre_free[b] ? ((int'(run_q) + b + 1) >= int'(need_q)) : !blocked;
    end
    fit_found = |fit_at;
    fit_bit = '0;
    for (int b = WordBits - 1; b >= 0; b--) begin
      if (fit_at[b]) fit_bit = 5'(b);
    end
    top_used = '0;
    for (int b = 0; b < WordBits; b++) begin
      if (word_eff[b]) top_used = 5'(b);
    end
    run_end = pre_free[WordBits-1] ? (run_q + CntW'(WordBits)) :
              CntW'(5'(WordBits - 1) - top_used);
  end

  // Mask of bits touched within the current word while marking
  logic [WordBits-1:0] mark_mask;
  logic [5:0] mark_n;
  logic [4:0] mark_lo;
  always_comb begin
    mark_lo = pos_q[4:0];
    mark_n = (left_q > CntW'(WordBits - mark_lo)) ? 6'(WordBits - mark_lo) : 6'(left_q);
    for (int b = 0; b < WordBits; b++) begin
      mark_mask[b] = (b >= mark_lo) && (b < int'(mark_lo) + int'(mark_n));
    end
  end

  // Free address decode
  logic [31:0] addr_off;
  logic misalign, out_heap;
  assign addr_off = address_i - heap_base_q;
  assign misalign = |addr_off[ShW-1:0];
  assign out_heap = (32'(addr_off >> ShW)) >= 32'(BlockCount);

  logic [31:0] need_full;
  assign need_full = 32'((32'(size_bytes_i) - 32'd1) >> ShW) + 32'd1;

  // Hold the base register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= HeapBaseReset;
    end else if (cfg_we_i) begin
      heap_base_q <= cfg_wdata_i;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:    if (clr_q == IdxW'(BlockCount - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (req_valid_i) begin
          if (operation_i == OP_FREE) begin
            state_d = (address_i == '0 || misalign || out_heap) ? S_DONE : S_FREE_RD;
          end else if (size_bytes_i == '0 || need_full > 32'(BlockCount)) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD:  state_d = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (fit_found) state_d = S_MARK_RD;
        else if (wa_q == WaW'(Words - 1)) state_d = S_DONE;
        else state_d = S_SCAN_RD;
      end
      S_FREE_RD:  state_d = S_FREE_CHK;
      S_FREE_CHK: state_d = (len_rdata == '0) ? S_DONE : S_MARK_RD;
      S_MARK_RD:  state_d = S_MARK_WR;
      S_MARK_WR:  state_d = (left_q == CntW'(mark_n)) ? S_DONE : S_MARK_RD;
      S_DONE:     if (rsp_ready_i) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    wa_d = wa_q; clr_d = clr_q; need_d = need_q; run_d = run_q; left_d = left_q;
    start_d = start_q; pos_d = pos_q; rsp_addr_d = rsp_addr_q; rsp_st_d = rsp_st_q;
    op_d = op_q;
    map_we = 1'b0; map_addr = wa_q; map_wdata = map_rdata | mark_mask;
    len_we = 1'b0; len_addr = start_q[IdxW-1:0]; len_wdata = need_q;
    req_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        map_we = 1'b1; map_addr = clr_q[IdxW-1 -: WaW]; map_wdata = '0;
        if (WaW >= IdxW) map_addr = WaW'(clr_q);
        len_we = 1'b1; len_addr = clr_q; len_wdata = '0;
        clr_d = clr_q + 1'b1;
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        rsp_addr_d = '0;
        op_d = operation_i;
        wa_d = '0; run_d = '0;
        need_d = CntW'(need_full);
        start_d = (IdxW + 1)'(addr_off >> ShW);
        if (operation_i == OP_FREE) begin
          rsp_st_d = (address_i == '0) ? ST_OK :
                     (misalign || out_heap) ? ST_NOT_ALLOCATED : ST_OK;
        end else begin
          rsp_st_d = (size_bytes_i == '0) ? ST_ILLEGAL_SIZE :
                     (need_full > 32'(BlockCount)) ? ST_NO_MEMORY : ST_OK;
        end
      end
      S_SCAN_RD: ;
      S_SCAN_CHK: begin
        if (fit_found) begin
          start_d = (IdxW + 1)'({wa_q, fit_bit}) + 1'b1 - (IdxW + 1)'(need_q);
          pos_d = (IdxW + 1)'({wa_q, fit_bit}) + 1'b1 - (IdxW + 1)'(need_q);
          left_d = need_q;
          rsp_addr_d = heap_base_q +
                       32'(32'({wa_q, fit_bit}) + 32'd1 - 32'(need_q)) * 32'(BlockBytes);
        end else if (wa_q == WaW'(Words - 1)) begin
          rsp_st_d = ST_NO_MEMORY;
        end else begin
          run_d = run_end;
          wa_d = wa_q + 1'b1;
        end
      end
      S_FREE_RD: ;
      S_FREE_CHK: begin
        left_d = len_rdata;
        pos_d = start_q;
        if (len_rdata == '0) rsp_st_d = ST_NOT_ALLOCATED;
      end
      S_MARK_RD: map_addr = WaW'(pos_q >> 5);
      S_MARK_WR: begin
        map_addr = WaW'(pos_q >> 5);
        map_we = 1'b1;
        map_wdata = (op_q == OP_FREE) ? (map_rdata & ~mark_mask) : (map_rdata | mark_mask);
        pos_d = pos_q + (IdxW + 1)'(mark_n);
        left_d = left_q - CntW'(mark_n);
        if (left_q == CntW'(mark_n)) begin
          len_we = 1'b1;
          len_wdata = (op_q == OP_FREE) ? '0 : need_q;
        end
      end
      default: ;
    endcase
  end

  // Advance state and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q <= wa_d; need_q <= need_d; run_q <= run_d; left_q <= left_d;
    start_q <= start_d; pos_q <= pos_d; rsp_addr_q <= rsp_addr_d;
    rsp_st_q <= rsp_st_d; op_q <= op_d;
  end

  assign rsp_valid_o = (state_q == S_DONE);
  assign block_address_o = rsp_addr_q;
  assign status_o = rsp_st_q;

endmodule

FILE: design/bfa_checker.sv
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level checks of the allocator core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bfa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_o,
  input logic        rsp_valid_o,
  input logic        rsp_ready_i,
  input logic [31:0] block_address_o,
  input logic [1:0]  status_o
);

  import bfa_pkg::*;

  `BFA_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, rsp_valid_o, !req_ready_o)
  `BFA_ASSERT_IMP(a_fail_zero, clk_i, rst_ni, rsp_valid_o && status_o != ST_OK, block_address_o == '0)
  `BFA_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_o && !rsp_ready_i, rsp_valid_o && $stable(status_o))
  `BFA_ASSERT_NXT(a_req_busy, clk_i, rst_ni, req_valid_i && req_ready_o, !req_ready_o)

endmodule

bind bitmap_first_fit_block_allocator_core bfa_checker u_bfa_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .req_valid_i(req_valid_i), .req_ready_o(req_ready_o),
  .rsp_valid_o(rsp_valid_o), .rsp_ready_i(rsp_ready_i),
  .block_address_o(block_address_o), .status_o(status_o)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bitmap first-fit block allocator: a local model
// of the block map predicts each response, and a response process compares it.
// ----------------------------------------------------------------------------
module tb;
  import bfa_pkg::*;

  localparam int unsigned BlkBytes = 128;
  localparam int unsigned BlkCount = 2048;

  typedef struct {
    logic [31:0] addr;
    status_e     st;
  } alloc_rsp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        req_valid = 1'b0;
  logic        req_ready;
  op_e         req_op = OP_ALLOC;
  logic [19:0] req_size = '0;
  logic [31:0] req_addr = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  logic [31:0] rsp_addr;
  logic [1:0]  rsp_status;

  // Model state of the heap
  logic [31:0] heap_base_m = HeapBaseReset;
  bit          blk_used [BlkCount];
  int unsigned blk_run  [BlkCount];
  int unsigned live_starts [$];

  alloc_rsp_t  pending_rsp_q [$];
  int unsigned mismatches = 0;
  bit          idle_en = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  bitmap_first_fit_block_allocator_core i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .req_valid_i     (req_valid),
    .req_ready_o     (req_ready),
    .operation_i     (req_op),
    .size_bytes_i    (req_size),
    .address_i       (req_addr),
    .rsp_valid_o     (rsp_valid),
    .rsp_ready_i     (rsp_ready),
    .block_address_o (rsp_addr),
    .status_o        (rsp_status)
  );

  always #10 clk = ~clk;

  // Work out the response of one accepted request and update the heap model
  function automatic alloc_rsp_t predict_allocation(op_e op, logic [19:0] sz,
                                                    logic [31:0] ad);
    alloc_rsp_t  r;
    int unsigned need, run, start, idx;
    logic [31:0] d;
    r.addr = '0;
    r.st   = ST_OK;
    if (op == OP_ALLOC) begin
      if (sz == 0) begin
        r.st = ST_ILLEGAL_SIZE;
        return r;
      end
      need = (sz - 1) / BlkBytes + 1;
      r.st = ST_NO_MEMORY;
      if (need > BlkCount) return r;
      run = 0;
      for (int i = 0; i < BlkCount; i++) begin
        run = blk_used[i] ? 0 : run + 1;
        if (run == need) begin
          start = i + 1 - need;
          for (int j = 0; j < need; j++) blk_used[start + j] = 1'b1;
          blk_run[start] = need;
          live_starts.push_back(start);
          r.addr = heap_base_m + start * BlkBytes;
          r.st   = ST_OK;
          return r;
        end
      end
      return r;
    end
    // Free: address zero is dropped before any lookup
    if (ad == 0) return r;
    d = ad - heap_base_m;
    idx = d / BlkBytes;
    if ((d % BlkBytes) != 0 || d / BlkBytes >= BlkCount || blk_run[idx] == 0) begin
      r.st = ST_NOT_ALLOCATED;
      return r;
    end
    for (int j = 0; j < blk_run[idx]; j++) blk_used[idx + j] = 1'b0;
    blk_run[idx] = 0;
    foreach (live_starts[k]) begin
      if (live_starts[k] == idx) begin
        live_starts.delete(k);
        break;
      end
    end
    return r;
  endfunction

  // Offer one request, hold it until taken, then record its expected response
  task automatic send_request(op_e op, logic [19:0] sz, logic [31:0] ad);
    alloc_rsp_t r;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_op    <= op;
    req_size  <= sz;
    req_addr  <= ad;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    r = predict_allocation(op, sz, ad);
    pending_rsp_q.push_back(r);
  endtask

  function automatic logic [31:0] live_addr(int unsigned idx);
    return heap_base_m + idx * BlkBytes;
  endfunction

  // Drain, let the block settle, then write the base register
  task automatic write_heap_base(logic [31:0] v);
    req_valid <= 1'b0;
    wait (pending_rsp_q.size() == 0);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we      <= 1'b0;
    heap_base_m  = v;
  endtask

  task automatic release_all();
    while (live_starts.size() != 0) begin
      // An allocation that sits at address zero can never be released: drop it
      if (live_addr(live_starts[0]) == 32'd0) live_starts.delete(0);
      else send_request(OP_FREE, 20'($urandom), live_addr(live_starts[0]));
    end
  endtask

  // Check each response against the oldest expectation and pace rsp_ready
  always @(posedge clk) begin
    alloc_rsp_t e;
    if (rst_n && rsp_valid && rsp_ready) begin
      if (pending_rsp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response addr=%h status=%0d", rsp_addr, rsp_status);
      end else begin
        e = pending_rsp_q.pop_front();
        if (rsp_addr !== e.addr || rsp_status !== e.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected addr=%h status=%0d, got addr=%h status=%0d",
                     e.addr, e.st, rsp_addr, rsp_status);
        end
      end
    end
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Size edges: zero, one byte, block boundaries, whole heap, over-size
  task automatic test_size_edges();
    send_request(OP_ALLOC, 20'd0, 32'hFFFF_FFFF);
    send_request(OP_ALLOC, 20'd1, '0);
    send_request(OP_ALLOC, 20'd128, '0);
    send_request(OP_ALLOC, 20'd129, '0);
    send_request(OP_ALLOC, 20'hFFFFF, '0);
    release_all();
    send_request(OP_ALLOC, 20'd262144, '0);
    send_request(OP_ALLOC, 20'd1, '0);
    release_all();
    send_request(OP_ALLOC, 20'd262145, '0);
  endtask

  // Free edges: zero, unaligned, outside heap, double free, orphaned by base move
  task automatic test_free_edges();
    logic [31:0] a;
    send_request(OP_ALLOC, 20'd300, '0);
    a = live_addr(live_starts[0]);
    send_request(OP_FREE, '0, 32'd0);
    send_request(OP_FREE, '0, a + 32'd4);
    send_request(OP_FREE, '0, heap_base_m + BlkBytes * BlkCount);
    send_request(OP_FREE, '0, heap_base_m - BlkBytes);
    send_request(OP_FREE, 20'hFFFFF, a);
    send_request(OP_FREE, '0, a);
    send_request(OP_ALLOC, 20'd1000, '0);
    write_heap_base(32'h0000_1000);
    send_request(OP_FREE, '0, a);
    release_all();
  endtask

  // Base extremes, a wrapping base and a zero base
  task automatic test_base_extremes();
    write_heap_base(32'hFFFC_0000);
    send_request(OP_ALLOC, 20'd5000, '0);
    release_all();
    write_heap_base(32'hFFFF_F000);
    send_request(OP_ALLOC, 20'd8192, '0);
    send_request(OP_ALLOC, 20'd64, '0);
    release_all();
    write_heap_base(32'h0000_0000);
    send_request(OP_ALLOC, 20'd10, '0);
    send_request(OP_FREE, '0, 32'd0);
    send_request(OP_ALLOC, 20'd10, '0);
    release_all();
  endtask

  // Mostly well-formed alloc/free traffic with some noise
  task automatic test_random_traffic(int n);
    int unsigned pick, k;
    logic [19:0] sz;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        if (pick < 2) sz = 20'($urandom);
        else if (pick < 8) sz = 20'($urandom_range(1, 32768));
        else sz = 20'($urandom_range(1, 1500));
        send_request(OP_ALLOC, sz, $urandom);
      end else if (pick < 92 && live_starts.size() != 0) begin
        k = $urandom_range(0, live_starts.size() - 1);
        send_request(OP_FREE, 20'($urandom), live_addr(live_starts[k]));
      end else if (pick < 95) begin
        send_request(OP_FREE, 20'($urandom), $urandom);
      end else if (pick < 97) begin
        send_request(OP_FREE, '0, 32'd0);
      end else begin
        send_request(OP_ALLOC, 20'd0, $urandom);
      end
    end
  endtask

  // Hold the response side off while requests keep coming
  task automatic test_backpressure();
    hold_req = 1'b1;
    test_random_traffic(20);
  endtask

  // Pause the sender until every response is back
  task automatic test_drain_pause();
    req_valid <= 1'b0;
    wait (pending_rsp_q.size() == 0);
    @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_size_edges();
    test_free_edges();
    test_base_extremes();
    write_heap_base(HeapBaseReset);
    test_random_traffic(600);
    test_backpressure();
    test_drain_pause();
    write_heap_base(32'h8000_0000);
    test_random_traffic(600);
    write_heap_base(32'h0000_1000);
    test_random_traffic(400);
    idle_en = 1'b0;
    test_random_traffic(400);
    req_valid <= 1'b0;
    wait (pending_rsp_q.size() == 0);
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #400_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
